>>> design/gjs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjs_pkg
// Shared sizes and types for the greedy job sequencing core.
// ----------------------------------------------------------------------------
package gjs_pkg;

  localparam int MAX_JOBS   = 32;
  localparam int MAX_SLOTS  = 64;
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = MAX_SLOTS / GROUP;

  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int DL_W     = 7;
  localparam int PROFIT_W = 16;
  localparam int TOTAL_W  = 21;
  localparam int GRP_W    = $clog2(NUM_GROUPS);
  localparam int BIT_W    = $clog2(GROUP);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // one stored job as it sits in a sorting cell
  typedef struct packed {
    logic                valid;
    logic [PROFIT_W-1:0] profit;
    logic [DL_W-1:0]     deadline;
    logic [IDX_W-1:0]    index;
  } job_entry_t;

  // chain control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  // slot search answer
  typedef struct packed {
    logic            found;
    logic [DL_W-1:0] slot;
  } slot_hit_t;

endpackage

>>> design/gjs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjs_cell
// One cell of the sorted job chain. Insert keeps the chain in falling
// profit order with ties in load order; shift moves every entry one cell
// toward the head.
// ----------------------------------------------------------------------------
module gjs_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  gjs_pkg::cell_ctl_t    ctl,
  input  gjs_pkg::job_entry_t   new_entry,
  input  gjs_pkg::job_entry_t   prev_entry,
  input  logic                  prev_gt,
  input  gjs_pkg::job_entry_t   next_entry,
  output gjs_pkg::job_entry_t   entry,
  output logic                  gt
);

  // new job beats the held one: empty cell or strictly higher profit
  assign gt = !entry.valid || (new_entry.profit > entry.profit);

  // hold, take the next entry on shift, take the new job, or take the neighbor that is pushed down
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end else if (ctl.ins && gt) begin
      entry <= prev_gt ? prev_entry : new_entry;
    end
  end

endmodule

>>> design/gjs_slot_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjs_slot_finder
// Slot map with a two-stage search for the latest free slot at or before
// a deadline. Stage one masks the map into groups, stage two encodes.
// ----------------------------------------------------------------------------
module gjs_slot_finder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      look,
  input  logic [gjs_pkg::DL_W-1:0]  deadline,
  output gjs_pkg::slot_hit_t        hit
);

  logic [gjs_pkg::MAX_SLOTS-1:0]                        busy_map;
  logic [gjs_pkg::NUM_GROUPS-1:0][gjs_pkg::GROUP-1:0]   avail;
  logic [gjs_pkg::NUM_GROUPS-1:0][gjs_pkg::GROUP-1:0]   avail_q;
  logic [gjs_pkg::NUM_GROUPS-1:0]                       grp;
  logic [gjs_pkg::NUM_GROUPS-1:0]                       grp_q;
  logic                                                 look_q;
  logic [gjs_pkg::GRP_W-1:0]                            sel_g;
  logic [gjs_pkg::BIT_W-1:0]                            sel_b;
  logic [gjs_pkg::GROUP-1:0]                            sel_bits;

  // free slots at or below the deadline, bit k stands for slot k+1
  always_comb begin
    for (int g = 0; g < gjs_pkg::NUM_GROUPS; g++) begin
      for (int b = 0; b < gjs_pkg::GROUP; b++) begin
        avail[g][b] = !busy_map[g*gjs_pkg::GROUP + b] &&
                      (gjs_pkg::DL_W'(g*gjs_pkg::GROUP + b) < deadline);
      end
      grp[g] = |avail[g];
    end
  end

  // stage one registers
  always_ff @(posedge clk) begin
    if (rst) begin
      look_q <= 1'b0;
    end else begin
      look_q <= look;
    end
  end

  always_ff @(posedge clk) begin
    if (look) begin
      avail_q <= avail;
      grp_q   <= grp;
    end
  end

  // stage two: highest group with a free slot, then highest bit in it
  always_comb begin
    sel_g = '0;
    for (int g = 0; g < gjs_pkg::NUM_GROUPS; g++) begin
      if (grp_q[g]) sel_g = gjs_pkg::GRP_W'(g);
    end
    sel_bits = avail_q[sel_g];
    sel_b = '0;
    for (int b = 0; b < gjs_pkg::GROUP; b++) begin
      if (sel_bits[b]) sel_b = gjs_pkg::BIT_W'(b);
    end
    hit.found = look_q && (|grp_q);
    hit.slot  = gjs_pkg::DL_W'({sel_g, sel_b}) + gjs_pkg::DL_W'(1);
  end

  // slot map: cleared per run, marked on each hit
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy_map <= '0;
    end else if (hit.found) begin
      busy_map[{sel_g, sel_b}] <= 1'b1;
    end
  end

endmodule

>>> design/greedy_job_sequencing_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_job_sequencing_core
// Loads jobs into a sorted cell chain, then schedules them greedily by
// profit into the latest free slot at or before each deadline.
// ----------------------------------------------------------------------------
// Loading takes a new job every clock while the core is idle; the insert into
// the sorted chain, while it has room, is done in the cycle the job is taken.
// After the last job each stored job passes two states (ST_LOOK masks the slot
// map, ST_PICK encodes), then one more ST_LOOK closes the run. A result waits
// until the next job gets a slot and comes out the cycle after that; the last
// one follows the closing state with run_end. The receiver cannot stall.
// Synchronous reset empties the chain, the slot map and the count.
module greedy_job_sequencing_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  job_deadline,
  input  logic [15:0] job_profit,
  input  logic        last_job,
  output logic        result_valid,
  output logic [4:0]  job_index,
  output logic [6:0]  slot_taken,
  output logic [15:0] job_gain,
  output logic [20:0] total_profit,
  output logic        run_end
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0]                          state;
  logic [gjs_pkg::CNT_W-1:0]           count;
  gjs_pkg::cell_ctl_t                  ctl;
  gjs_pkg::job_entry_t                 new_entry;
  gjs_pkg::job_entry_t                 held [gjs_pkg::MAX_JOBS];
  logic [gjs_pkg::MAX_JOBS-1:0]        gt;
  gjs_pkg::job_entry_t                 head;
  gjs_pkg::slot_hit_t                  hit;
  logic                                accept;
  logic                                look;
  logic [gjs_pkg::IDX_W-1:0]           cur_index;
  logic [gjs_pkg::PROFIT_W-1:0]        cur_gain;
  logic [gjs_pkg::TOTAL_W-1:0]         total;
  logic [gjs_pkg::TOTAL_W-1:0]         total_next;
  logic [gjs_pkg::TOTAL_W:0]           total_sum;
  logic                                pend_valid;
  logic [gjs_pkg::IDX_W-1:0]           pend_index;
  logic [gjs_pkg::DL_W-1:0]            pend_slot;
  logic [gjs_pkg::PROFIT_W-1:0]        pend_gain;
  logic [gjs_pkg::TOTAL_W-1:0]         pend_total;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign head   = held[0];
  assign look   = (state == ST_LOOK) && head.valid;

  // incoming job, deadline saturated to the slot range
  always_comb begin
    new_entry.valid    = 1'b1;
    new_entry.profit   = job_profit;
    new_entry.deadline = (job_deadline > gjs_pkg::DL_W'(gjs_pkg::MAX_SLOTS)) ?
                         gjs_pkg::DL_W'(gjs_pkg::MAX_SLOTS) : job_deadline;
    new_entry.index    = count[gjs_pkg::IDX_W-1:0];
  end

  // chain control: insert while loading, shift one per visited job
  always_comb begin
    ctl.ins   = accept && (count < gjs_pkg::CNT_W'(gjs_pkg::MAX_JOBS));
    ctl.shift = look;
  end

  // sorted chain of job cells
  for (genvar i = 0; i < gjs_pkg::MAX_JOBS; i++) begin : g_chain
    gjs_pkg::job_entry_t prev_e;
    gjs_pkg::job_entry_t next_e;
    logic                prev_g;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = held[i-1];
      assign prev_g = gt[i-1];
    end
    if (i == gjs_pkg::MAX_JOBS - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = held[i+1];
    end
    gjs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_gt    (prev_g),
      .next_entry (next_e),
      .entry      (held[i]),
      .gt         (gt[i])
    );
  end

  // slot map and search
  gjs_slot_finder u_slot (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept && last_job),
    .look     (look),
    .deadline (head.deadline),
    .hit      (hit)
  );

  // saturating running total
  always_comb begin
    total_sum  = {1'b0, total} + (gjs_pkg::TOTAL_W + 1)'(cur_gain);
    total_next = total_sum[gjs_pkg::TOTAL_W] ? gjs_pkg::TOTAL_MAX :
                 total_sum[gjs_pkg::TOTAL_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (ctl.ins) count <= count + gjs_pkg::CNT_W'(1);
          if (accept && last_job) begin
            state      <= ST_LOOK;
            pend_valid <= 1'b0;
            total      <= '0;
          end
        end
        ST_LOOK: begin
          if (head.valid) begin
            cur_index <= head.index;
            cur_gain  <= head.profit;
            state     <= ST_PICK;
          end else begin
            // close the run, last held result carries run_end
            if (pend_valid) begin
              result_valid <= 1'b1;
              job_index    <= pend_index;
              slot_taken   <= pend_slot;
              job_gain     <= pend_gain;
              total_profit <= pend_total;
              run_end      <= 1'b1;
            end
            pend_valid <= 1'b0;
            count      <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_PICK: begin
          if (hit.found) begin
            if (pend_valid) begin
              result_valid <= 1'b1;
              job_index    <= pend_index;
              slot_taken   <= pend_slot;
              job_gain     <= pend_gain;
              total_profit <= pend_total;
              run_end      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_index <= cur_index;
            pend_slot  <= hit.slot;
            pend_gain  <= cur_gain;
            pend_total <= total_next;
            total      <= total_next;
          end
          state <= ST_LOOK;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for greedy_job_sequencing_core. Job sets are fed through the
// start/busy handshake in bursts with random gaps. Each accepted job also
// goes into a behavioral scheduler that builds the expected slot grants in
// visit order. A monitor compares every result strobe with the oldest grant.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_JOBS    = 320;

  typedef struct {
    logic [gjs_pkg::DL_W-1:0]     deadline;
    logic [gjs_pkg::PROFIT_W-1:0] profit;
    logic                         last;
    bit                           drain;  // hold this job until all grants are out
  } job_t;

  typedef struct {
    logic [gjs_pkg::IDX_W-1:0]    index;
    logic [gjs_pkg::DL_W-1:0]     slot;
    logic [gjs_pkg::PROFIT_W-1:0] gain;
    logic [gjs_pkg::TOTAL_W-1:0]  total;
    logic                         run_end;
  } grant_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [6:0]          job_deadline;
  logic [15:0]         job_profit;
  logic                last_job;
  logic                result_valid;
  logic [4:0]          job_index;
  logic [6:0]          slot_taken;
  logic [15:0]         job_gain;
  logic [20:0]         total_profit;
  logic                run_end;

  job_t   job_feed_q[$];
  grant_t grant_q[$];
  job_t   cur_job;

  // scheduler state, mirrors the core's job store
  logic [gjs_pkg::DL_W-1:0]     held_dl [gjs_pkg::MAX_JOBS];
  logic [gjs_pkg::PROFIT_W-1:0] held_pr [gjs_pkg::MAX_JOBS];
  int                           held_cnt;
  logic [gjs_pkg::DL_W-1:0]     held_top;

  logic in_fire;
  int   burst_left;
  int   gap_left;
  int   idle_cycles;
  int   err_cnt;
  int   fed_jobs;

  greedy_job_sequencing_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .job_deadline (job_deadline),
    .job_profit   (job_profit),
    .last_job     (last_job),
    .result_valid (result_valid),
    .job_index    (job_index),
    .slot_taken   (slot_taken),
    .job_gain     (job_gain),
    .total_profit (total_profit),
    .run_end      (run_end)
  );

  always #5 clk = ~clk;

  // store one job and, on the last job, schedule the whole set
  task automatic load_and_schedule(input logic [gjs_pkg::DL_W-1:0] dl_in,
                                   input logic [gjs_pkg::PROFIT_W-1:0] pr_in,
                                   input logic fin);
    logic [gjs_pkg::DL_W-1:0]    dl;
    bit [gjs_pkg::MAX_SLOTS:0]   slot_used;
    bit [gjs_pkg::MAX_JOBS-1:0]  visited;
    int                          best;
    int                          top;
    int                          s;
    int                          v;
    int                          i;
    int                          n;
    bit                          placed;
    int unsigned                 total;
    grant_t                      g;
    dl = (dl_in > gjs_pkg::MAX_SLOTS) ? gjs_pkg::DL_W'(gjs_pkg::MAX_SLOTS) : dl_in;
    if (held_cnt < gjs_pkg::MAX_JOBS) begin
      held_dl[held_cnt] = dl;
      held_pr[held_cnt] = pr_in;
      held_cnt++;
      if (dl > held_top) held_top = dl;
    end
    if (fin) begin
      slot_used = '0;
      visited   = '0;
      total     = 0;
      n         = 0;
      for (v = 0; v < held_cnt; v++) begin
        // highest profit first, earlier load wins a tie
        best = -1;
        for (i = 0; i < held_cnt; i++) begin
          if (!visited[i] && (best < 0 || held_pr[i] > held_pr[best])) best = i;
        end
        visited[best] = 1'b1;
        top = (held_dl[best] > held_top) ? held_top : held_dl[best];
        placed = 1'b0;
        // latest free slot at or before the deadline
        for (s = top; s >= 1 && !placed; s--) begin
          if (!slot_used[s]) begin
            slot_used[s] = 1'b1;
            placed = 1'b1;
            total = total + held_pr[best];
            if (total > gjs_pkg::TOTAL_MAX) total = gjs_pkg::TOTAL_MAX;
            g.index   = gjs_pkg::IDX_W'(best);
            g.slot    = gjs_pkg::DL_W'(s);
            g.gain    = held_pr[best];
            g.total   = gjs_pkg::TOTAL_W'(total);
            g.run_end = 1'b0;
            grant_q.insert(grant_q.size(), g);
            n++;
          end
        end
      end
      if (n > 0) grant_q[grant_q.size() - 1].run_end = 1'b1;
      held_cnt = 0;
      held_top = '0;
    end
  endtask

  task automatic add_job(input int dl, input int pr, input bit fin, input bit drain);
    job_t j;
    j.deadline = gjs_pkg::DL_W'(dl);
    j.profit   = gjs_pkg::PROFIT_W'(pr);
    j.last     = fin;
    j.drain    = drain;
    job_feed_q.insert(job_feed_q.size(), j);
    fed_jobs++;
  endtask

  // monitor: result check, job acceptance and watchdog
  always @(posedge clk) begin
    grant_t g;
    in_fire <= !rst && start && !busy;
    if (!rst) begin
      if (result_valid) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: job_index %0d slot_taken %0d", job_index, slot_taken);
          err_cnt++;
        end else begin
          g = grant_q.pop_front();
          if (job_index !== g.index) begin
            $error("job_index: expected %0d, got %0d", g.index, job_index);
            err_cnt++;
          end
          if (slot_taken !== g.slot) begin
            $error("slot_taken: expected %0d, got %0d", g.slot, slot_taken);
            err_cnt++;
          end
          if (job_gain !== g.gain) begin
            $error("job_gain: expected %0d, got %0d", g.gain, job_gain);
            err_cnt++;
          end
          if (total_profit !== g.total) begin
            $error("total_profit: expected %0d, got %0d", g.total, total_profit);
            err_cnt++;
          end
          if (run_end !== g.run_end) begin
            $error("run_end: expected %0d, got %0d", g.run_end, run_end);
            err_cnt++;
          end
        end
      end
      if (start && !busy) load_and_schedule(job_deadline, job_profit, last_job);
      if ((start && !busy) || result_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !in_fire) begin
      // transaction still waiting on busy
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (job_feed_q.size() == 0 || (job_feed_q[0].drain && grant_q.size() != 0)) begin
      start <= 1'b0;
    end else begin
      cur_job = job_feed_q.pop_front();
      start        <= 1'b1;
      job_deadline <= cur_job.deadline;
      job_profit   <= cur_job.profit;
      last_job     <= cur_job.last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(0, 5);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  initial begin
    int  size;
    int  cap;
    int  r;
    int  dl;
    int  pr;
    bit  ties;
    bit  drain;
    bit  first;
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    job_deadline = '0;
    job_profit   = '0;
    last_job     = 1'b0;
    in_fire      = 1'b0;
    burst_left   = 1;
    gap_left     = 0;
    idle_cycles  = 0;
    err_cnt      = 0;
    fed_jobs     = 0;
    held_cnt     = 0;
    held_top     = '0;

    // single job at the extremes
    add_job(1, 16'hFFFF, 1, 0);
    // deadline zero alone: no result
    add_job(0, 16'h1234, 1, 0);
    // saturated deadlines, zero profit, ties and alternating bit patterns
    add_job(127, 0, 0, 1);
    add_job(64, 16'hFFFF, 0, 0);
    add_job(3, 100, 0, 0);
    add_job(3, 100, 0, 0);
    add_job(3, 100, 0, 0);
    add_job(1, 100, 0, 0);
    add_job(2, 16'h8000, 0, 0);
    add_job(85, 1, 0, 0);
    add_job(0, 16'h5555, 0, 0);
    add_job(42, 16'hAAAA, 1, 0);
    // empty run after a full drain
    add_job(0, 5, 0, 1);
    add_job(0, 6, 1, 0);
    // one slot, three contenders, tie on the top profit
    add_job(1, 10, 0, 0);
    add_job(1, 20, 0, 0);
    add_job(1, 20, 1, 0);

    // random sets; the first overflows the job store
    first = 1'b1;
    while (fed_jobs < RANDOM_JOBS) begin
      if (first) size = gjs_pkg::MAX_JOBS + 2;
      else if ($urandom_range(0, 9) == 0)
        size = $urandom_range(gjs_pkg::MAX_JOBS - 2, gjs_pkg::MAX_JOBS + 4);
      else size = $urandom_range(1, 12);
      first = 1'b0;
      cap   = ($urandom_range(0, 3) == 0) ? gjs_pkg::MAX_SLOTS : $urandom_range(1, 16);
      ties  = ($urandom_range(0, 3) == 0);
      drain = ($urandom_range(0, 7) == 0);
      for (int j = 0; j < size; j++) begin
        r  = $urandom_range(0, 19);
        dl = (r == 0) ? 0 : (r == 1) ? $urandom_range(gjs_pkg::MAX_SLOTS + 1, 127)
                                     : $urandom_range(1, cap);
        if (ties) pr = $urandom_range(1, 4);
        else if (r == 2) pr = 16'hFFFF;
        else if (r == 3) pr = 0;
        else pr = $urandom_range(0, 16'hFFFF);
        add_job(dl, pr, j == size - 1, drain && j == 0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for the feed to empty, then for the last grants
    while (job_feed_q.size() != 0 || start) @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
